// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define SBWU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sbwu assertion failed");

// clocked assertion that also holds through reset
`define SBWU_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("sbwu assertion failed");

`endif

// ===== rtl/core/sbwu_pkg.sv =====
package sbwu_pkg;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [7:0] EXP_MAX = 8'hFF;

	typedef struct packed {
		logic nan;
		logic inf;
		logic infsign;
	} spec_t;

	typedef struct packed {
		logic [31:0] pn;
		logic sticky;
		logic signed [10:0] e_n;
	} norm_t;

	typedef struct packed {
		logic [26:0] mbig;
		logic [26:0] msmall;
		logic sub;
		logic [7:0] ebig;
		logic sign;
		logic zsign;
		spec_t sp;
	} align_t;

endpackage

// ===== rtl/core/sbwu_if.sv =====
interface sbwu_item_if;
	logic valid;
	logic ready;
	logic [15:0] weight_high;
	logic [15:0] weight_low;
	logic [15:0] gradient;
	logic last_in;

	modport source(output valid, output weight_high, output weight_low, output gradient,
		output last_in, input ready);
	modport sink(input valid, input weight_high, input weight_low, input gradient,
		input last_in, output ready);
endinterface

interface sbwu_result_if;
	logic valid;
	logic ready;
	logic [15:0] new_high;
	logic [15:0] new_low;
	logic last_out;

	modport source(output valid, output new_high, output new_low, output last_out,
		input ready);
	modport sink(input valid, input new_high, input new_low, input last_out,
		output ready);
endinterface

// ===== rtl/core/sbwu_mul.sv =====
module sbwu_mul import sbwu_pkg::*; (
	input logic [31:0] lr,
	input logic [15:0] grad,
	output logic [31:0] p,
	output logic signed [9:0] k,
	output logic sign,
	output spec_t sp
);

	logic [7:0] ea, eb, ea1, eb1;
	logic [22:0] fa;
	logic [6:0] fb;
	logic nan_a, inf_a, zero_a, nan_b, inf_b, zero_b;
	logic signed [10:0] ksum;

	always_comb begin
		ea = lr[30:23];
		fa = lr[22:0];
		eb = grad[14:7];
		fb = grad[6:0];
		nan_a = (ea == EXP_MAX) && (fa != '0);
		inf_a = (ea == EXP_MAX) && (fa == '0);
		zero_a = (ea == '0) && (fa == '0);
		nan_b = (eb == EXP_MAX) && (fb != '0);
		inf_b = (eb == EXP_MAX) && (fb == '0);
		zero_b = (eb == '0) && (fb == '0);
		ea1 = (ea == '0) ? 8'd1 : ea;
		eb1 = (eb == '0) ? 8'd1 : eb;
		p = {ea != '0, fa} * {eb != '0, fb};
		ksum = $signed({3'b0, ea1}) + $signed({3'b0, eb1}) - 11'sd157;
		k = ksum[9:0];
		sign = lr[31] ^ grad[15];
		sp.nan = nan_a | nan_b | (inf_a & zero_b) | (zero_a & inf_b);
		sp.inf = inf_a | inf_b;
		sp.infsign = lr[31] ^ grad[15];
	end

endmodule

// ===== rtl/core/sbwu_norm.sv =====
module sbwu_norm import sbwu_pkg::*; (
	input logic [31:0] x,
	input logic signed [9:0] k,
	output norm_t nrm
);

	logic [4:0] lead;
	logic [5:0] sa;
	logic signed [10:0] kx, sb, s, neg;
	logic [4:0] r;
	logic [31:0] mask;

	always_comb begin
		lead = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) lead = 5'(i);
		end
		sa = 6'd31 - {1'b0, lead};
		kx = {k[9], k};
		sb = 11'sd30 + kx;
		s = (sb < $signed({5'b0, sa})) ? sb : $signed({5'b0, sa});
		neg = -s;
		r = neg[4:0];
		mask = (32'h1 << r) - 32'h1;
		nrm.e_n = $signed({6'b0, lead}) + kx;
		if (!s[10]) begin
			nrm.pn = x << s[4:0];
			nrm.sticky = 1'b0;
		end else if (neg > 11'sd31) begin
			nrm.pn = '0;
			nrm.sticky = |x;
		end else begin
			nrm.pn = x >> r;
			nrm.sticky = |(x & mask);
		end
	end

endmodule

// ===== rtl/core/sbwu_round.sv =====
module sbwu_round import sbwu_pkg::*; (
	input norm_t nrm,
	output logic [30:0] mag
);

	logic normal, inc;
	logic [31:0] base;

	always_comb begin
		normal = nrm.pn[31];
		inc = nrm.pn[7] & ((|nrm.pn[6:0]) | nrm.sticky | nrm.pn[8]);
		base = {1'b0, (normal ? nrm.e_n[7:0] : 8'h00), nrm.pn[30:8]} + {31'b0, inc};
		if (normal && (nrm.e_n > 11'sd254)) begin
			mag = {EXP_MAX, 23'b0};
		end else if (base[31:23] >= 9'd255) begin
			mag = {EXP_MAX, 23'b0};
		end else begin
			mag = base[30:0];
		end
	end

endmodule

// ===== rtl/core/sbwu_align.sv =====
module sbwu_align import sbwu_pkg::*; (
	input logic [31:0] a,
	input logic [31:0] b,
	output align_t al
);

	logic nan_a, inf_a, nan_b, inf_b, a_big;
	logic [31:0] big, lesser;
	logic [7:0] eb1, es1, d;
	logic [23:0] ms;
	logic [26:0] ext, sh, mask;

	always_comb begin
		nan_a = (a[30:23] == EXP_MAX) && (a[22:0] != '0);
		inf_a = (a[30:23] == EXP_MAX) && (a[22:0] == '0);
		nan_b = (b[30:23] == EXP_MAX) && (b[22:0] != '0);
		inf_b = (b[30:23] == EXP_MAX) && (b[22:0] == '0);
		a_big = a[30:0] >= b[30:0];
		big = a_big ? a : b;
		lesser = a_big ? b : a;
		eb1 = (big[30:23] == '0) ? 8'd1 : big[30:23];
		es1 = (lesser[30:23] == '0) ? 8'd1 : lesser[30:23];
		d = eb1 - es1;
		ms = {lesser[30:23] != '0, lesser[22:0]};
		ext = {ms, 3'b0};
		sh = ext >> d[4:0];
		mask = (27'h1 << d[4:0]) - 27'h1;
		al.mbig = {big[30:23] != '0, big[22:0], 3'b0};
		if (d >= 8'd27) begin
			al.msmall = {26'b0, |ms};
		end else begin
			al.msmall = {sh[26:1], sh[0] | (|(ext & mask))};
		end
		al.sub = a[31] ^ b[31];
		al.ebig = eb1;
		al.sign = big[31];
		al.zsign = a[31] & b[31];
		al.sp.nan = nan_a | nan_b | (inf_a & inf_b & (a[31] != b[31]));
		al.sp.inf = inf_a | inf_b;
		al.sp.infsign = inf_a ? a[31] : b[31];
	end

endmodule

// ===== rtl/core/split_bf16_weight_update.sv =====
// split_bf16_weight_update: streaming sgd step on fp32 weights kept as two halves
// item channel carries weight_high, weight_low, gradient (bf16) and last_in
// result channel returns new_high, new_low and last_out in the same order
// new weight = weight + round(learning_rate * gradient), both ops fp32 rne,
// subnormals kept, any nan result given as 0x7fc00000
// learning_rate is written through cfg_we / cfg_wdata; the user must write it only
// while the block is idle, since the block itself does not enforce this
// throughput: one transaction per cycle when the receiver does not stall; the
// stages are multiply, product normalize, product round, align, add, sum normalize,
// sum round into the output register
// each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and a stalled receiver backs up
// the pipe one stage at a time; item.ready drops only when all 7 stages are full
// reset (arst_n low) empties every stage and clears learning_rate to zero
module split_bf16_weight_update import sbwu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	sbwu_item_if.sink item,
	sbwu_result_if.source result
);

	logic [31:0] lr_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

	logic [31:0] p_c;
	logic signed [9:0] k_c;
	logic sign_c;
	spec_t sp_c;
	norm_t nrm_p_c, nrm_a_c;
	logic [30:0] mag_p_c, mag_a_c;
	align_t al_c;
	logic [27:0] sum_c;

	logic [31:0] p_s1, w_s1, w_s2, w_s3, prod_s3, res_s7;
	logic signed [9:0] k_s1, k_s5;
	logic sign_s1, sign_s2, sign_s5, sign_s6;
	spec_t sp_s1, sp_s2, sp_s5, sp_s6;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7;
	norm_t nrm_s2, nrm_s6;
	align_t al_s4;
	logic [27:0] sum_s5;

	assign adv7 = !v_s7 || result.ready;
	assign adv6 = !v_s6 || adv7;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign item.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= '0;
		end else if (cfg_we) begin
			lr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= item.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
			if (adv7) v_s7 <= v_s6;
		end
	end

	sbwu_mul u_mul (
		.lr(lr_q),
		.grad(item.gradient),
		.p(p_c),
		.k(k_c),
		.sign(sign_c),
		.sp(sp_c)
	);

	sbwu_norm u_norm_p (
		.x(p_s1),
		.k(k_s1),
		.nrm(nrm_p_c)
	);

	sbwu_round u_round_p (
		.nrm(nrm_s2),
		.mag(mag_p_c)
	);

	sbwu_align u_align (
		.a(w_s3),
		.b(prod_s3),
		.al(al_c)
	);

	assign sum_c = al_s4.sub ? ({1'b0, al_s4.mbig} - {1'b0, al_s4.msmall})
		: ({1'b0, al_s4.mbig} + {1'b0, al_s4.msmall});

	sbwu_norm u_norm_a (
		.x({sum_s5, 4'b0}),
		.k(k_s5),
		.nrm(nrm_a_c)
	);

	sbwu_round u_round_a (
		.nrm(nrm_s6),
		.mag(mag_a_c)
	);

	always_ff @(posedge clk) begin
		if (adv1) begin
			p_s1 <= p_c;
			k_s1 <= k_c;
			sign_s1 <= sign_c;
			sp_s1 <= sp_c;
			w_s1 <= {item.weight_high, item.weight_low};
			last_s1 <= item.last_in;
		end
		if (adv2) begin
			nrm_s2 <= nrm_p_c;
			sign_s2 <= sign_s1;
			sp_s2 <= sp_s1;
			w_s2 <= w_s1;
			last_s2 <= last_s1;
		end
		if (adv3) begin
			if (sp_s2.nan) begin
				prod_s3 <= CANON_NAN;
			end else if (sp_s2.inf) begin
				prod_s3 <= {sp_s2.infsign, EXP_MAX, 23'b0};
			end else begin
				prod_s3 <= {sign_s2, mag_p_c};
			end
			w_s3 <= w_s2;
			last_s3 <= last_s2;
		end
		if (adv4) begin
			al_s4 <= al_c;
			last_s4 <= last_s3;
		end
		if (adv5) begin
			sum_s5 <= sum_c;
			k_s5 <= $signed({2'b0, al_s4.ebig}) - 10'sd30;
			sign_s5 <= (sum_c == '0) ? al_s4.zsign : al_s4.sign;
			sp_s5 <= al_s4.sp;
			last_s5 <= last_s4;
		end
		if (adv6) begin
			nrm_s6 <= nrm_a_c;
			sign_s6 <= sign_s5;
			sp_s6 <= sp_s5;
			last_s6 <= last_s5;
		end
		if (adv7) begin
			if (sp_s6.nan) begin
				res_s7 <= CANON_NAN;
			end else if (sp_s6.inf) begin
				res_s7 <= {sp_s6.infsign, EXP_MAX, 23'b0};
			end else begin
				res_s7 <= {sign_s6, mag_a_c};
			end
			last_s7 <= last_s6;
		end
	end

	assign result.valid = v_s7;
	assign result.new_high = res_s7[31:16];
	assign result.new_low = res_s7[15:0];
	assign result.last_out = last_s7;

endmodule

// ===== rtl/core/sbwu_checker.sv =====
`include "assert_macros.svh"

module sbwu_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic [15:0] new_high,
	input logic [15:0] new_low,
	input logic last_out
);

	// a waiting result keeps its transaction on the port
	`SBWU_ASSERT(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid)

	`SBWU_ASSERT(a_res_stable, clk, arst_n, res_valid && !res_ready |=> $stable(new_high) && $stable(new_low) && $stable(last_out))

	// every nan leaves as the canonical quiet pattern
	`SBWU_ASSERT(a_nan_canon, clk, arst_n, res_valid && new_high[14:7] == 8'hFF && (new_high[6:0] != 7'h0 || new_low != 16'h0) |-> new_high == 16'h7FC0 && new_low == 16'h0)

	// pipe comes out of reset empty
	`SBWU_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !res_valid)

endmodule

bind split_bf16_weight_update sbwu_checker u_sbwu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.new_high(result.new_high),
	.new_low(result.new_low),
	.last_out(result.last_out)
);

// ===== bench/testbench.sv =====
typedef struct {
	logic [15:0] new_high;
	logic [15:0] new_low;
	logic last_out;
} wu_result_t;

class weight_update_scoreboard;
	wu_result_t updates_due[$];
	int errors = 0;

	static function real fp32_to_real(logic [31:0] f);
		logic [63:0] d;
		logic [22:0] frac;
		int k;
		d = {f[31], 63'd0};
		if (f[30:23] == 8'hFF) begin
			d = {f[31], 11'h7FF, f[22:0], 29'd0};
		end else if (f[30:23] == 8'd0) begin
			if (f[22:0] != 0) begin
				frac = f[22:0];
				k = 0;
				while (!frac[22]) begin
					frac = frac << 1;
					k++;
				end
				frac = frac << 1;
				d = {f[31], 11'(1023 - 127 - k), frac, 29'd0};
			end
		end else begin
			d = {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0};
		end
		return $bitstoreal(d);
	endfunction

	// round a double to single, nearest-even, subnormals kept, nan made canonical
	static function logic [31:0] real_to_fp32(real r);
		logic [63:0] b;
		logic [63:0] mant;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		int ef;
		int sh;
		b = $realtobits(r);
		if (b[62:52] == 11'h7FF)
			return (b[51:0] != 0) ? sbwu_pkg::CANON_NAN : {b[63], 8'hFF, 23'd0};
		if (b[62:52] == 11'd0)
			return {b[63], 31'd0};
		ef = int'(b[62:52]) - 1023 + 127;
		mant = {11'd0, 1'b1, b[51:0]};
		sh = (ef >= 1) ? 29 : 30 - ef;
		if (sh >= 60)
			return {b[63], 31'd0};
		q = mant >> sh;
		rem = mant & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0]))
			q++;
		if (ef < 1)
			return {b[63], q[30:0]};
		if (q[24]) begin
			q = q >> 1;
			ef++;
		end
		if (ef >= 255)
			return {b[63], 8'hFF, 23'd0};
		return {b[63], 8'(ef), q[22:0]};
	endfunction

	function void note_item(logic [31:0] rate, logic [15:0] wh, logic [15:0] wl,
		logic [15:0] grad, logic last);
		logic [31:0] prod;
		logic [31:0] sum;
		wu_result_t e;
		prod = real_to_fp32(fp32_to_real(rate) * fp32_to_real({grad, 16'd0}));
		sum = real_to_fp32(fp32_to_real({wh, wl}) + fp32_to_real(prod));
		e.new_high = sum[31:16];
		e.new_low = sum[15:0];
		e.last_out = last;
		updates_due.insert(updates_due.size(), e);
	endfunction

	function void check_result(logic [15:0] nh, logic [15:0] nl, logic lo);
		wu_result_t e;
		if (updates_due.size() == 0) begin
			$error("unexpected result transaction");
			errors++;
			return;
		end
		e = updates_due.pop_front();
		if (nh !== e.new_high) begin
			$error("new_high expected %h actual %h", e.new_high, nh);
			errors++;
		end
		if (nl !== e.new_low) begin
			$error("new_low expected %h actual %h", e.new_low, nl);
			errors++;
		end
		if (lo !== e.last_out) begin
			$error("last_out expected %b actual %b", e.last_out, lo);
			errors++;
		end
	endfunction

	function int pending();
		return updates_due.size();
	endfunction
endclass

module testbench;
	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;
	logic [31:0] rate_now;
	int cycles;
	int sent;
	bit no_idle_send;
	weight_update_scoreboard sb;

	sbwu_item_if item_ch();
	sbwu_result_if result_ch();

	split_bf16_weight_update uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(item_ch),
		.result(result_ch)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 300000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready)
			sb.note_item(rate_now, item_ch.weight_high, item_ch.weight_low,
				item_ch.gradient, item_ch.last_in);
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.new_high, result_ch.new_low, result_ch.last_out);
	end

	// receiver: random stalls, one long hold-off, one stretch always ready
	initial begin
		int n;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		for (n = 0; ; n++) begin
			@(posedge clk);
			if (n >= 300 && n < 450)
				result_ch.ready <= 1'b0;
			else if (n >= 700 && n < 1200)
				result_ch.ready <= 1'b1;
			else
				result_ch.ready <= ($urandom_range(99) >= 13);
		end
	end

	function automatic logic [15:0] pick_half();
		logic [15:0] h;
		int c;
		h = 16'($urandom);
		c = $urandom_range(99);
		if (c < 20)
			h[14:7] = 8'h00;
		else if (c < 30)
			h[14:7] = 8'hFF;
		else if (c < 55)
			h[14:7] = 8'($urandom_range(140, 114));
		else if (c < 60)
			h[14:7] = 8'hFE;
		return h;
	endfunction

	task automatic send_item(logic [15:0] wh, logic [15:0] wl, logic [15:0] grad, logic last);
		item_ch.valid <= 1'b1;
		item_ch.weight_high <= wh;
		item_ch.weight_low <= wl;
		item_ch.gradient <= grad;
		item_ch.last_in <= last;
		do @(negedge clk); while (!item_ch.ready);
		@(posedge clk);
		sent++;
		if (!no_idle_send && $urandom_range(99) < 13) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_rate(logic [31:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		rate_now <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random(int count);
		int i;
		logic [15:0] wl;
		for (i = 0; i < count; i++) begin
			wl = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
			send_item(pick_half(), wl, pick_half(), 1'($urandom));
		end
	endtask

	initial begin
		logic [31:0] rates[8];
		int p;
		sb = new();
		cycles = 0;
		sent = 0;
		no_idle_send = 0;
		rate_now = 32'd0;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 32'd0;
		item_ch.valid <= 1'b0;
		item_ch.weight_high <= 16'd0;
		item_ch.weight_low <= 16'd0;
		item_ch.gradient <= 16'd0;
		item_ch.last_in <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset rate is zero: zero times infinity
		send_item(16'h3F80, 16'h0000, 16'h7F80, 1'b0);
		send_item(16'h4000, 16'h1234, 16'h3F80, 1'b1);

		write_rate(32'h3F80_0000);
		send_item(16'h0000, 16'h0000, 16'h8000, 1'b0);
		send_item(16'h8000, 16'h0000, 16'h0000, 1'b1);
		send_item(16'h8000, 16'h0000, 16'h8000, 1'b0);
		send_item(16'h7F80, 16'h0000, 16'hFF80, 1'b0);
		send_item(16'hFF80, 16'h0000, 16'hFF80, 1'b1);
		send_item(16'h7FC0, 16'h0001, 16'h3F80, 1'b0);
		send_item(16'h3F80, 16'h0000, 16'hFFC1, 1'b0);
		send_item(16'h7F7F, 16'hFFFF, 16'h7F7F, 1'b1);
		send_item(16'hFF7F, 16'hFFFF, 16'hFF7F, 1'b0);
		send_item(16'h0000, 16'h0001, 16'h0001, 1'b0);
		send_item(16'h807F, 16'hFFFF, 16'h0040, 1'b1);
		send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_item(16'h3F80, 16'h0000, 16'hBF80, 1'b0);
		send_item(16'h3F80, 16'h0001, 16'h3380, 1'b0);
		send_item(16'h3F80, 16'h0000, 16'h3380, 1'b1);
		send_item(16'h4B80, 16'h0001, 16'h3F00, 1'b0);

		write_rate(32'h7F7F_FFFF);
		send_item(16'h3F80, 16'h0000, 16'h4000, 1'b0);
		send_item(16'h3F80, 16'h0000, 16'h0001, 1'b1);
		write_rate(32'h0000_0001);
		send_item(16'h0000, 16'h0000, 16'h3F00, 1'b0);
		send_item(16'h0000, 16'h0000, 16'h3FC0, 1'b1);

		rates = '{32'h3C23_D70A, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7F80_0000,
			32'h8000_0001, 32'hBF80_0000, 32'h7F7F_FFFF, 32'h0000_0001};
		for (p = 0; p < 10; p++) begin
			if (p < 8)
				write_rate(rates[p]);
			else
				write_rate($urandom);
			if (p == 2) begin
				no_idle_send = 1;
				send_random(150);
				no_idle_send = 0;
				drain();
			end
			send_random(p == 0 ? 400 : 100);
		end

		drain();
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
